FILE: rtl/zdcd_pkg.sv
// ----------------------------------------------------------------------------
// zdcd_pkg
// Shared field widths, the node count reset value and the search status bundle for the
// zero-delay cycle detector.
// ----------------------------------------------------------------------------
package zdcd_pkg;

    localparam int NODE_IDX_W   = 5;
    localparam int DELAY_W      = 32;
    localparam int NODE_COUNT_W = 6;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 6'd32;

    typedef struct packed {
        logic busy;
        logic result_valid;
        logic found;
    } search_status_t;

endpackage

FILE: rtl/zdcd_edge_mem.sv
// ----------------------------------------------------------------------------
// zdcd_edge_mem
// Adjacency matrix: one row of predecessor bits per dependent node, held in a
// synchronous RAM with a per-row valid bit so that a whole graph clears at once.
// ----------------------------------------------------------------------------
module zdcd_edge_mem #(
    parameter int MAX_NODES = 32,
    localparam int AW = $clog2(MAX_NODES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [MAX_NODES-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [MAX_NODES-1:0] rd_data
);

    logic [MAX_NODES-1:0] mem [MAX_NODES];
    logic [MAX_NODES-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [MAX_NODES-1:0] row_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A row that has not been written since the last clear reads as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: rtl/zdcd_stack_mem.sv
// ----------------------------------------------------------------------------
// zdcd_stack_mem
// Search stack storage: saved node and scan position of each suspended level,
// a synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module zdcd_stack_mem #(
    parameter int DEPTH   = 32,
    parameter int ENTRY_W = 11,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/zdcd_search.sv
// ----------------------------------------------------------------------------
// zdcd_search
// Depth-first search sequencer. Scans one matrix column per cycle between row
// fetches, keeps three-state visit marks and spills suspended levels to a RAM.
// ----------------------------------------------------------------------------
module zdcd_search
    import zdcd_pkg::*;
#(
    parameter int MAX_NODES = 32,
    localparam int NW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CW-1:0]        node_limit,
    input  logic                 result_ack,
    output search_status_t       status,
    output logic                 row_rd_en,
    output logic [NW-1:0]        row_rd_addr,
    input  logic [MAX_NODES-1:0] row_rd_data
);

    localparam int ENTRY_W = NW + CW;
    localparam logic [CW-1:0] DEPTH_MAX = CW'(MAX_NODES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETTLE,
        S_START,
        S_ROWWAIT,
        S_SCAN,
        S_POPWAIT,
        S_RESULT
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        start_reg, start_next;
    logic [CW-1:0]        depth_reg, depth_next;
    logic [NW-1:0]        top_node_reg, top_node_next;
    logic [CW-1:0]        top_scan_reg, top_scan_next;
    logic [MAX_NODES-1:0] row_reg, row_next;
    logic [MAX_NODES-1:0] visiting_reg, visiting_next;
    logic [MAX_NODES-1:0] done_reg, done_next;
    logic                 found_reg, found_next;

    logic               stk_wr_en;
    logic [NW-1:0]      stk_wr_addr;
    logic [ENTRY_W-1:0] stk_wr_data;
    logic               stk_rd_en;
    logic [NW-1:0]      stk_rd_addr;
    logic [ENTRY_W-1:0] stk_rd_data;

    logic [NW-1:0] start_idx;
    logic [NW-1:0] scan_idx;
    logic [CW-1:0] scan_inc;
    logic [CW-1:0] lvl_top;
    logic [CW-1:0] lvl_below;

    assign start_idx = start_reg[NW-1:0];
    assign scan_idx  = top_scan_reg[NW-1:0];
    assign scan_inc  = top_scan_reg + CW'(1);
    assign lvl_top   = depth_reg - CW'(1);
    assign lvl_below = depth_reg - CW'(2);

    zdcd_stack_mem #(
        .DEPTH   (MAX_NODES),
        .ENTRY_W (ENTRY_W)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        start_next    = start_reg;
        depth_next    = depth_reg;
        top_node_next = top_node_reg;
        top_scan_next = top_scan_reg;
        row_next      = row_reg;
        visiting_next = visiting_reg;
        done_next     = done_reg;
        found_next    = found_reg;
        row_rd_en     = 1'b0;
        row_rd_addr   = top_node_reg;
        stk_wr_en     = 1'b0;
        stk_wr_addr   = lvl_top[NW-1:0];
        stk_wr_data   = {top_node_reg, scan_inc};
        stk_rd_en     = 1'b0;
        stk_rd_addr   = lvl_below[NW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = node_limit;
                    start_next = '0;
                    depth_next = '0;
                    found_next = 1'b0;
                    state_next = S_SETTLE;
                end
            end
            // The final item's matrix write lands in this cycle.
            S_SETTLE:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                if (start_reg >= n_reg)
                begin
                    found_next = 1'b0;
                    state_next = S_RESULT;
                end
                else if (visiting_reg[start_idx] || done_reg[start_idx])
                begin
                    start_next = start_reg + CW'(1);
                end
                else
                begin
                    visiting_next[start_idx] = 1'b1;
                    depth_next    = CW'(1);
                    top_node_next = start_idx;
                    top_scan_next = '0;
                    row_rd_en     = 1'b1;
                    row_rd_addr   = start_idx;
                    state_next    = S_ROWWAIT;
                end
            end
            S_ROWWAIT:
            begin
                row_next   = row_rd_data;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (top_scan_reg >= n_reg)
                begin
                    // Every column of this node is scanned: retire it.
                    done_next[top_node_reg]     = 1'b1;
                    visiting_next[top_node_reg] = 1'b0;
                    depth_next = lvl_top;
                    if (depth_reg == CW'(1))
                    begin
                        start_next = start_reg + CW'(1);
                        state_next = S_START;
                    end
                    else
                    begin
                        stk_rd_en  = 1'b1;
                        state_next = S_POPWAIT;
                    end
                end
                else if (row_reg[scan_idx])
                begin
                    if (visiting_reg[scan_idx])
                    begin
                        found_next = 1'b1;
                        state_next = S_RESULT;
                    end
                    else if (!done_reg[scan_idx] && (depth_reg < DEPTH_MAX))
                    begin
                        stk_wr_en = 1'b1;
                        visiting_next[scan_idx] = 1'b1;
                        top_node_next = scan_idx;
                        top_scan_next = '0;
                        depth_next    = depth_reg + CW'(1);
                        row_rd_en     = 1'b1;
                        row_rd_addr   = scan_idx;
                        state_next    = S_ROWWAIT;
                    end
                    else
                    begin
                        top_scan_next = scan_inc;
                    end
                end
                else
                begin
                    top_scan_next = scan_inc;
                end
            end
            S_POPWAIT:
            begin
                top_node_next = stk_rd_data[ENTRY_W-1:CW];
                top_scan_next = stk_rd_data[CW-1:0];
                row_rd_en     = 1'b1;
                row_rd_addr   = stk_rd_data[ENTRY_W-1:CW];
                state_next    = S_ROWWAIT;
            end
            S_RESULT:
            begin
                if (result_ack)
                begin
                    visiting_next = '0;
                    done_next     = '0;
                    depth_next    = '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            start_reg    <= '0;
            depth_reg    <= '0;
            visiting_reg <= '0;
            done_reg     <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            start_reg    <= start_next;
            depth_reg    <= depth_next;
            visiting_reg <= visiting_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_node_reg <= top_node_next;
        top_scan_reg <= top_scan_next;
        row_reg      <= row_next;
    end

    assign status.busy         = (state_reg != S_IDLE);
    assign status.result_valid = (state_reg == S_RESULT);
    assign status.found        = found_reg;

endmodule

FILE: rtl/zero_delay_cycle_detect_top.sv
// ----------------------------------------------------------------------------
// zero_delay_cycle_detect_top
// Zero-delay cycle detector: collects dependency edges into an adjacency
// matrix and reports whether the zero-delay edges form any directed cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Edge items arrive on edge_valid/edge_stall with dependent, predecessor,
//   delay, edge_present and last_edge. An edge with zero delay and both
//   indices below MAX_NODES is stored; one item is taken every cycle while
//   the block loads, the matrix row being read, updated and written back
//   with forwarding between neighbouring items.
//   The item with last_edge set starts the search: edge_stall rises and
//   stays high until the result is handed to the output register. The
//   search has a settle step, then tries each start position in turn; per
//   visited node it fetches the row, scans its columns and retires it, and
//   it returns to a parent through a stack read and a new row fetch.
//   One item, cycle_found, then appears on flag_valid/flag_stall. It waits
//   in its register while the receiver stalls; new edges are accepted
//   meanwhile, but a further search holds its result until the flag is taken.
//   node_count is written through node_count_we/node_count_wdata; the user
//   must write it only while idle, which the block itself does not enforce.
//   Reset empties the matrix and visit marks at once and sets node_count to
//   32; they are emptied again, just as fast, after every graph.
// ----------------------------------------------------------------------------
module zero_delay_cycle_detect_top
    import zdcd_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    node_count_we,
    input  logic [NODE_COUNT_W-1:0] node_count_wdata,
    input  logic                    edge_valid,
    output logic                    edge_stall,
    input  logic [NODE_IDX_W-1:0]   dependent,
    input  logic [NODE_IDX_W-1:0]   predecessor,
    input  logic [DELAY_W-1:0]      delay,
    input  logic                    edge_present,
    input  logic                    last_edge,
    output logic                    flag_valid,
    input  logic                    flag_stall,
    output logic                    cycle_found
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int EXT_W = (CW > NODE_COUNT_W) ? CW : NODE_COUNT_W;

    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic [EXT_W-1:0]        count_ext;
    logic [EXT_W-1:0]        max_ext;
    logic [CW-1:0]           node_limit;

    search_status_t       status;
    logic                 srch_rd_en;
    logic [NW-1:0]        srch_rd_addr;
    logic                 res_ack;

    logic                 edge_accept;
    logic                 store;
    logic                 mem_rd_en;
    logic [NW-1:0]        mem_rd_addr;
    logic [MAX_NODES-1:0] mem_rd_data;
    logic [MAX_NODES-1:0] base_row;
    logic [MAX_NODES-1:0] new_row;

    logic                 s1_valid_reg;
    logic [NW-1:0]        s1_row_reg;
    logic [NW-1:0]        s1_col_reg;
    logic                 fwd_valid_reg;
    logic [NW-1:0]        fwd_row_reg;
    logic [MAX_NODES-1:0] fwd_data_reg;

    logic                 flag_valid_reg;
    logic                 cycle_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (node_count_we)
        begin
            node_count_reg <= node_count_wdata;
        end
    end

    assign count_ext  = EXT_W'(node_count_reg);
    assign max_ext    = EXT_W'(MAX_NODES);
    assign node_limit = (count_ext > max_ext) ? CW'(max_ext) : CW'(count_ext);

    assign edge_stall  = status.busy;
    assign edge_accept = edge_valid && !edge_stall;
    assign store = edge_accept && edge_present && (delay == '0)
                   && (32'(dependent) < MAX_NODES) && (32'(predecessor) < MAX_NODES);

    // Load reads the row in the accept cycle and writes it back in the next cycle.
    assign mem_rd_en   = store || srch_rd_en;
    assign mem_rd_addr = status.busy ? srch_rd_addr : NW'(dependent);

    // The previous item's write lands in the same cycle as this item's read.
    assign base_row = (fwd_valid_reg && (fwd_row_reg == s1_row_reg)) ? fwd_data_reg
                                                                    : mem_rd_data;
    assign new_row  = base_row | (MAX_NODES'(1) << s1_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= store;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg   <= NW'(dependent);
        s1_col_reg   <= NW'(predecessor);
        fwd_row_reg  <= s1_row_reg;
        fwd_data_reg <= new_row;
    end

    zdcd_edge_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_edge_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (res_ack),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_row_reg),
        .wr_data (new_row),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    zdcd_search #(
        .MAX_NODES (MAX_NODES)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (edge_accept && last_edge),
        .node_limit  (node_limit),
        .result_ack  (res_ack),
        .status      (status),
        .row_rd_en   (srch_rd_en),
        .row_rd_addr (srch_rd_addr),
        .row_rd_data (mem_rd_data)
    );

    assign res_ack = status.result_valid && (!flag_valid_reg || !flag_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_valid_reg <= 1'b0;
        end
        else if (res_ack)
        begin
            flag_valid_reg <= 1'b1;
        end
        else if (!flag_stall)
        begin
            flag_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            cycle_found_reg <= status.found;
        end
    end

    assign flag_valid  = flag_valid_reg;
    assign cycle_found = cycle_found_reg;

`ifndef SYNTH
    // A pending matrix write must land before the search fetches any row.
    a_no_read_over_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !srch_rd_en)
        else $error("search read the matrix while an edge write was pending");

    // A finished search never coincides with an accepted edge item.
    a_no_edge_at_result: assert property (@(posedge clk) disable iff (!rst_n)
        status.result_valid |-> !edge_accept)
        else $error("edge item accepted while a search result was pending");

    // A new flag only ever follows a handed-over search result.
    a_flag_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flag_valid_reg) |-> $past(res_ack))
        else $error("flag raised without a search result");
`endif

endmodule
